// ===== rtl/wfms_pkg.sv =====
package wfms_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int IDX_W           = 6;
	localparam int VALUE_W         = 45;
	localparam int WSL_W           = 3;
	localparam int HOP_W           = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;
	localparam int MAX_POINTS_DEF  = 128;
	localparam int COEF_BITS_DEF   = 16;
	localparam int COEF_MAX_W      = 25;
	localparam int WIN_TAB_DEPTH   = 256;
	localparam int TW_TAB_DEPTH    = 64;
	localparam int ROOT_TOP_BIT    = 44;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	localparam logic [WSL_W-1:0] WSL_RESET = 3'd7;
	localparam logic [HOP_W-1:0] HOP_RESET = 8'd64;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LENGTH       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MODE      = 2'd2;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef logic signed [COEF_MAX_W-1:0] coef_t;
	typedef coef_t win_tab_t [WIN_TAB_DEPTH];
	typedef coef_t tw_tab_t [TW_TAB_DEPTH];

	typedef struct packed {
		longint c;
		longint s;
	} trig_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_WRU,
		ST_BF_WRT,
		ST_MAG_RD,
		ST_MAG_SQ,
		ST_MAG_SUM,
		ST_MAG_ROOT,
		ST_MAG_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic hist_wr;
		logic load_issue;
		logic bf_rd;
		logic bf_mul;
		logic bf_wru;
		logic bf_wrt;
		logic mag_rd;
		logic mag_sq;
		logic mag_sum;
		logic root_step;
		logic out_load;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic root_last;
		logic out_free;
	} dp_stat_t;

	// largest L with 2^L within the history depth, at least 2 and at most 7
	function automatic int lmax_of(input int max_points);
		int l;
		int t;
		l = 2;
		for (t = 2; t < 7; t++) begin
			if ((2 << l) <= max_points)
				l = l + 1;
		end
		return l;
	endfunction

	// shift-subtract division, evaluated on constants only
	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint series_q30(input logic [63:0] t0, input int n0,
		input logic [63:0] x2);
		longint acc;
		logic [63:0] term;
		logic [63:0] nn;
		int k;
		acc = longint'(t0);
		term = t0;
		nn = 64'(n0);
		for (k = 0; k < 14; k++) begin
			term = udiv((term * x2) >> 30, (nn + 64'd1) * (nn + 64'd2));
			nn = nn + 64'd2;
			if (k[0])
				acc = acc + longint'(term);
			else
				acc = acc - longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > Q30_ONE)
			acc = Q30_ONE;
		return acc;
	endfunction

	function automatic trig_t trig_q30(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] th;
		logic [63:0] x2;
		longint c0;
		longint s0;
		trig_t res;
		q = udiv(64'd4 * a, b);
		r = 64'd4 * a - q * b;
		th = udiv(PI_HALF_Q30 * r, b);
		x2 = (th * th) >> 30;
		c0 = series_q30(64'(Q30_ONE), 0, x2);
		s0 = series_q30(th, 1, x2);
		case (q[1:0])
			2'd0: begin
				res.c = c0;
				res.s = s0;
			end
			2'd1: begin
				res.c = -s0;
				res.s = c0;
			end
			2'd2: begin
				res.c = -c0;
				res.s = -s0;
			end
			default: begin
				res.c = s0;
				res.s = -c0;
			end
		endcase
		return res;
	endfunction

	// round half up of v / 2^sh
	function automatic longint round_shr(input longint v, input int sh);
		logic [63:0] u;
		u = 64'(v + (longint'(1) << 31)) + (64'd1 << (sh - 1));
		return longint'(u >> sh) - longint'((64'd1 << 31) >> sh);
	endfunction

	// Hann windows for every L, packed back to back from offset 2^L - 4
	function automatic win_tab_t build_win(input int lmax, input int coef_bits);
		win_tab_t tab;
		int l;
		int i;
		int len;
		logic [63:0] a;
		trig_t tr;
		for (i = 0; i < WIN_TAB_DEPTH; i++)
			tab[i] = '0;
		for (l = 2; l <= lmax; l++) begin
			len = 1 << l;
			for (i = 0; i < len; i++) begin
				a = (i == len - 1) ? 64'd0 : 64'(i);
				tr = trig_q30(a, 64'(len - 1));
				tab[len - 4 + i] = coef_t'(round_shr(Q30_ONE - tr.c, 31 - (coef_bits - 1)));
			end
		end
		return tab;
	endfunction

	function automatic tw_tab_t build_twid(input int lmax, input int coef_bits,
		input logic want_im);
		tw_tab_t tab;
		int i;
		int n;
		trig_t tr;
		n = 1 << lmax;
		for (i = 0; i < TW_TAB_DEPTH; i++)
			tab[i] = '0;
		for (i = 0; i < n / 2; i++) begin
			tr = trig_q30(64'(i), 64'(n));
			if (want_im)
				tab[i] = coef_t'(round_shr(-tr.s, 30 - (coef_bits - 1)));
			else
				tab[i] = coef_t'(round_shr(tr.c, 30 - (coef_bits - 1)));
		end
		return tab;
	endfunction

endpackage

// ===== rtl/windowed_fft_magnitude_spectrogram_core.sv =====
// Streaming spectrogram core. Each accepted item is one signed 16-bit audio
// sample. Once N = 2^window_size_log2 samples have arrived, and from then on
// every hop_length samples, the core windows the newest N samples with a
// symmetric Hann window, runs a radix-2 FFT and delivers bins 0..N/2-1 in
// order, each the floor magnitude or, with square_mode set, the squared
// magnitude, with frame_last on the final bin. A sample that starts no frame
// is taken without a stall. A sample that starts a frame holds sample_stall high
// until the frame's last bin sits in the output register: windowing of N samples,
// then (N/2)*log2(N) butterflies on the single-write work memory, then per bin
// a read, square and sum plus a bit-serial square root (none in square mode)
// plus any time bin_stall holds the output. Change configuration only while idle.
module windowed_fft_magnitude_spectrogram_core import wfms_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COEF_BITS  = COEF_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       bin_valid,
	input  logic                       bin_stall,
	output logic [IDX_W-1:0]           bin_index,
	output logic [VALUE_W-1:0]         bin_value,
	output logic                       frame_last
);

	localparam int LMAX  = lmax_of(MAX_POINTS);
	localparam int CNT_W = LMAX + 1;

	logic [WSL_W-1:0] window_size_log2_q;
	logic [HOP_W-1:0] hop_length_q;
	logic             square_mode_q;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [WSL_W-1:0] l_sel;
	logic [WSL_W-1:0] stage;
	logic [CNT_W-1:0] cnt;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_log2_q <= WSL_RESET;
			hop_length_q       <= HOP_RESET;
			square_mode_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW_SIZE_LOG2: window_size_log2_q <= cfg_data[WSL_W-1:0];
				REG_HOP_LENGTH:       hop_length_q       <= cfg_data[HOP_W-1:0];
				REG_SQUARE_MODE:      square_mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame sequencing: fill and hop tracking, loop counters
	wfms_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.window_size_log2 (window_size_log2_q),
		.hop_length       (hop_length_q),
		.square_mode      (square_mode_q),
		.cmd              (cmd),
		.stat             (stat),
		.l_sel            (l_sel),
		.stage            (stage),
		.cnt              (cnt)
	);

	// history, window, butterfly, magnitude and output register
	wfms_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COEF_BITS (COEF_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.l_sel       (l_sel),
		.stage       (stage),
		.cnt         (cnt),
		.square_mode (square_mode_q),
		.sample      (sample),
		.bin_stall   (bin_stall),
		.bin_valid   (bin_valid),
		.bin_index   (bin_index),
		.bin_value   (bin_value),
		.frame_last  (frame_last)
	);

endmodule

// ===== rtl/wfms_ctrl.sv =====
module wfms_ctrl import wfms_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int LMAX = lmax_of(MAX_POINTS),
	localparam int CNT_W = LMAX + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  logic [WSL_W-1:0] window_size_log2,
	input  logic [HOP_W-1:0] hop_length,
	input  logic             square_mode,
	output dp_cmd_t          cmd,
	input  dp_stat_t         stat,
	output logic [WSL_W-1:0] l_sel,
	output logic [WSL_W-1:0] stage,
	output logic [CNT_W-1:0] cnt
);

	localparam logic [CNT_W-1:0] NMAX = CNT_W'(1 << LMAX);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] filled_q, filled_d;
	logic [HOP_W-1:0] hop_q, hop_d;
	logic [WSL_W-1:0] l_q, l_d;
	logic [WSL_W-1:0] stage_q, stage_d;

	logic [WSL_W-1:0] l_eff;
	logic [HOP_W-1:0] hop_eff;
	logic [HOP_W-1:0] hop_inc;
	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] n_frame;
	logic [CNT_W-1:0] half_frame;
	logic [CNT_W-1:0] filled_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			filled_q <= '0;
			hop_q    <= '0;
			l_q      <= 3'd2;
			stage_q  <= 3'd1;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			filled_q <= filled_d;
			hop_q    <= hop_d;
			l_q      <= l_d;
			stage_q  <= stage_d;
		end
	end

	always_comb begin
		if (window_size_log2 < 3'd2)
			l_eff = 3'd2;
		else if (window_size_log2 > 3'(LMAX))
			l_eff = 3'(LMAX);
		else
			l_eff = window_size_log2;
		hop_eff    = (hop_length == '0) ? 8'd1 : hop_length;
		hop_inc    = hop_q + 8'd1;
		n_eff      = CNT_W'(1) << l_eff;
		n_frame    = CNT_W'(1) << l_q;
		half_frame = n_frame >> 1;
		filled_inc = (filled_q < NMAX) ? filled_q + CNT_W'(1) : filled_q;

		state_d  = state_q;
		cnt_d    = cnt_q;
		filled_d = filled_q;
		hop_d    = hop_q;
		l_d      = l_q;
		stage_d  = stage_q;
		cmd      = '0;
		cmd.last = (cnt_q == half_frame - CNT_W'(1));

		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.hist_wr = 1'b1;
					filled_d = filled_inc;
					if (filled_inc >= n_eff) begin
						if (filled_q < n_eff) begin
							hop_d   = '0;
							l_d     = l_eff;
							cnt_d   = '0;
							state_d = ST_LOAD;
						end else if (hop_inc >= hop_eff) begin
							hop_d   = '0;
							l_d     = l_eff;
							cnt_d   = '0;
							state_d = ST_LOAD;
						end else begin
							hop_d = hop_inc;
						end
					end
				end
			end
			ST_LOAD: begin
				cmd.load_issue = 1'b1;
				if (cnt_q == n_frame - CNT_W'(1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN1;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: begin
				stage_d = 3'd1;
				cnt_d   = '0;
				state_d = ST_BF_RD;
			end
			ST_BF_RD: begin
				cmd.bf_rd = 1'b1;
				state_d = ST_BF_MUL;
			end
			ST_BF_MUL: begin
				cmd.bf_mul = 1'b1;
				state_d = ST_BF_WRU;
			end
			ST_BF_WRU: begin
				cmd.bf_wru = 1'b1;
				state_d = ST_BF_WRT;
			end
			ST_BF_WRT: begin
				cmd.bf_wrt = 1'b1;
				if (cnt_q == half_frame - CNT_W'(1)) begin
					cnt_d = '0;
					if (stage_q == l_q) begin
						state_d = ST_MAG_RD;
					end else begin
						stage_d = stage_q + 3'd1;
						state_d = ST_BF_RD;
					end
				end else begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_BF_RD;
				end
			end
			ST_MAG_RD: begin
				cmd.mag_rd = 1'b1;
				state_d = ST_MAG_SQ;
			end
			ST_MAG_SQ: begin
				cmd.mag_sq = 1'b1;
				state_d = ST_MAG_SUM;
			end
			ST_MAG_SUM: begin
				cmd.mag_sum = 1'b1;
				state_d = square_mode ? ST_MAG_OUT : ST_MAG_ROOT;
			end
			ST_MAG_ROOT: begin
				cmd.root_step = 1'b1;
				if (stat.root_last)
					state_d = ST_MAG_OUT;
			end
			ST_MAG_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (cmd.last) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						cnt_d   = cnt_q + CNT_W'(1);
						state_d = ST_MAG_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign l_sel = l_q;
	assign stage = stage_q;
	assign cnt   = cnt_q;

endmodule

// ===== rtl/wfms_dp.sv =====
module wfms_dp import wfms_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COEF_BITS  = COEF_BITS_DEF,
	localparam int LMAX = lmax_of(MAX_POINTS),
	localparam int CNT_W = LMAX + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic [WSL_W-1:0]           l_sel,
	input  logic [WSL_W-1:0]           stage,
	input  logic [CNT_W-1:0]           cnt,
	input  logic                       square_mode,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       bin_stall,
	output logic                       bin_valid,
	output logic [IDX_W-1:0]           bin_index,
	output logic [VALUE_W-1:0]         bin_value,
	output logic                       frame_last
);

	localparam int NMAX    = 1 << LMAX;
	localparam int AW      = LMAX;
	localparam int TW_AW   = LMAX - 1;
	localparam int WORK_W  = SAMPLE_W + LMAX + 2;
	localparam int COEF_W  = COEF_BITS + 1;
	localparam int FRAC    = COEF_BITS - 1;
	localparam int WPROD_W = SAMPLE_W + COEF_W;
	localparam int PROD_W  = WORK_W + COEF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int SQ_W    = 2 * WORK_W;
	localparam int SQS_W   = (SQ_W + 1 > VALUE_W) ? SQ_W + 1 : VALUE_W + 1;
	localparam logic [AW-1:0] TW_MASK = AW'(MAX_POINTS - 1);

	localparam win_tab_t WIN_TAB = build_win(LMAX, COEF_BITS);
	localparam tw_tab_t  TW_RE   = build_twid(LMAX, COEF_BITS, 1'b0);
	localparam tw_tab_t  TW_IM   = build_twid(LMAX, COEF_BITS, 1'b1);

	// sample history, circular
	logic signed [SAMPLE_W-1:0] hist_mem [NMAX];
	logic [AW-1:0]              wp_q;
	logic [CNT_W-1:0]           hist_full;
	logic [AW-1:0]              hist_addr;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;

	// windowing pipeline
	logic                      vld_s1, vld_s2;
	logic [AW-1:0]             idx_s1, idx_s2;
	logic signed [WPROD_W-1:0] prod_s2;
	logic [8:0]                win_full;
	logic signed [COEF_W-1:0]  win_coef;
	logic signed [WORK_W-1:0]  xw;
	logic [AW-1:0]             rev_full;
	logic [AW-1:0]             rev_addr;

	// work memory, real in the upper half
	logic [2*WORK_W-1:0] work_mem [NMAX];
	logic [2*WORK_W-1:0] rda_q, rdb_q;
	logic                wk_we;
	logic [AW-1:0]       wk_waddr;
	logic [2*WORK_W-1:0] wk_wdata;

	// butterfly
	logic [WSL_W-1:0]         s_m1;
	logic [AW-1:0]            bw, half, jj, u_addr, t_addr, ti;
	logic signed [COEF_W-1:0] wr_q, wi_q;
	logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic signed [WORK_W-1:0] ur, ui, br, bi, tr, tim;
	logic signed [SUM_W-1:0]  d_re, d_im;
	logic [2*WORK_W-1:0]      diff_q;

	// magnitude
	logic [WORK_W-1:0]  ar, ai;
	logic [SQ_W-1:0]    sq_re_q, sq_im_q;
	logic [SQS_W-1:0]   sq_sum;
	logic [VALUE_W-1:0] sq_sat;
	logic [VALUE_W-1:0] sq_q;
	logic [VALUE_W-1:0] rem_q, res_q, bit_q, trial;

	logic out_valid_q;

	// history
	assign hist_full = CNT_W'(wp_q) - (CNT_W'(1) << l_sel) + cnt;
	assign hist_addr = hist_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.hist_wr)
				wp_q <= wp_q + AW'(1);
			vld_s1 <= cmd.load_issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hist_wr)
			hist_mem[wp_q] <= sample;
		hist_rd_s1 <= hist_mem[hist_addr];
	end

	// window and bit-reversed placement
	assign win_full = (9'd1 << l_sel) - 9'd4 + 9'(idx_s1);
	assign win_coef = WIN_TAB[win_full[7:0]][COEF_W-1:0];
	assign xw = WORK_W'(prod_s2 >>> FRAC);

	always_comb begin
		for (int b = 0; b < AW; b++)
			rev_full[b] = idx_s2[AW-1-b];
		rev_addr = rev_full >> (3'(AW) - l_sel);
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt[AW-1:0];
		idx_s2  <= idx_s1;
		prod_s2 <= hist_rd_s1 * win_coef;
	end

	// butterfly addressing
	always_comb begin
		s_m1   = stage - 3'd1;
		bw     = cnt[AW-1:0];
		half   = AW'(1) << s_m1;
		jj     = bw & (half - AW'(1));
		u_addr = ((bw >> s_m1) << stage) | jj;
		t_addr = u_addr | half;
		ti     = (jj << (3'(AW) - stage)) & TW_MASK;
	end

	assign ur = rda_q[2*WORK_W-1:WORK_W];
	assign ui = rda_q[WORK_W-1:0];
	assign br = rdb_q[2*WORK_W-1:WORK_W];
	assign bi = rdb_q[WORK_W-1:0];
	assign d_re = SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
	assign d_im = SUM_W'(p_ri_q) + SUM_W'(p_ir_q);
	assign tr   = WORK_W'(d_re >>> FRAC);
	assign tim  = WORK_W'(d_im >>> FRAC);

	always_ff @(posedge clk) begin
		if (cmd.bf_rd) begin
			wr_q <= TW_RE[ti[TW_AW-1:0]][COEF_W-1:0];
			wi_q <= TW_IM[ti[TW_AW-1:0]][COEF_W-1:0];
		end
		if (cmd.bf_mul) begin
			p_rr_q <= wr_q * br;
			p_ii_q <= wi_q * bi;
			p_ri_q <= wr_q * bi;
			p_ir_q <= wi_q * br;
		end
		if (cmd.bf_wru)
			diff_q <= {ur - tr, ui - tim};
	end

	// single write port: windowed load, then upper and lower butterfly legs
	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = u_addr;
		wk_wdata = {ur + tr, ui + tim};
		if (vld_s2) begin
			wk_we    = 1'b1;
			wk_waddr = rev_addr;
			wk_wdata = {xw, {WORK_W{1'b0}}};
		end else if (cmd.bf_wru) begin
			wk_we = 1'b1;
		end else if (cmd.bf_wrt) begin
			wk_we    = 1'b1;
			wk_waddr = t_addr;
			wk_wdata = diff_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wk_we)
			work_mem[wk_waddr] <= wk_wdata;
		if (cmd.bf_rd) begin
			rda_q <= work_mem[u_addr];
			rdb_q <= work_mem[t_addr];
		end else if (cmd.mag_rd) begin
			rda_q <= work_mem[cnt[AW-1:0]];
		end
	end

	// magnitude and root
	assign ar = ur[WORK_W-1] ? WORK_W'(-ur) : WORK_W'(ur);
	assign ai = ui[WORK_W-1] ? WORK_W'(-ui) : WORK_W'(ui);
	assign sq_sum = SQS_W'(sq_re_q) + SQS_W'(sq_im_q);
	assign sq_sat = (sq_sum > SQS_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(sq_sum);
	assign trial  = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.mag_sq) begin
			sq_re_q <= ar * ar;
			sq_im_q <= ai * ai;
		end
		if (cmd.mag_sum) begin
			sq_q  <= sq_sat;
			rem_q <= sq_sat;
			res_q <= '0;
			bit_q <= VALUE_W'(1) << ROOT_TOP_BIT;
		end else if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// output register
	assign stat.root_last = bit_q[0];
	assign stat.out_free  = !out_valid_q || !bin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!bin_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bin_index  <= IDX_W'(cnt);
			bin_value  <= square_mode ? sq_q : res_q;
			frame_last <= cmd.last;
		end
	end

	assign bin_valid = out_valid_q;

endmodule
